/* hw/rtl/cpba_pkg.sv */
// ----------------------------------------------------------------------------
// cpba_pkg
// Shared constants, codes and types of the contiguous page bitmap allocator.
// ----------------------------------------------------------------------------
package cpba_pkg;

  // Page map geometry
  localparam int MAX_PAGES  = 4096;
  localparam int PAGE_SHIFT = 21;
  localparam int WORD_BITS  = 64;
  localparam int MAP_WORDS  = MAX_PAGES / WORD_BITS;
  localparam int WADDR_W    = $clog2(MAP_WORDS);
  localparam int OFF_W      = $clog2(WORD_BITS);

  // Field widths
  localparam int CNT_W   = 6;
  localparam int ADDR_W  = 48;
  localparam int PIDX_W  = ADDR_W - PAGE_SHIFT;
  localparam int PAGE_W  = 12;
  localparam int REG_W   = 13;
  localparam int STAT_W  = 3;
  localparam logic [REG_W-1:0] USED_MAX  = 13'd8191;
  localparam logic [REG_W-1:0] PAGE_LIM  = 13'd4096;

  // Operation codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_COUNT = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NO_ROOM   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_MISALIGN  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_RANGE     = 3'd4;

  // Configuration register indexes
  localparam logic REG_NUM_PAGES = 1'b0;
  localparam logic REG_RESERVED  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FREE_RD0,
    ST_FREE_RD1,
    ST_FREE_CAP,
    ST_WR_LO,
    ST_WR_HI,
    ST_DONE
  } state_t;

  // Write request into the page map
  typedef struct packed {
    logic                 we;
    logic [WADDR_W-1:0]   addr;
    logic [WORD_BITS-1:0] data;
  } map_wr_t;

  // Answer of the run fit unit
  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] off;
  } fit_t;

endpackage

/* hw/rtl/cpba_map.sv */
// ----------------------------------------------------------------------------
// cpba_map
// Page bitmap memory: one word per 64 pages, one write and one registered
// read per cycle. Per-row valid bits make rows never written read as free.
// ----------------------------------------------------------------------------
module cpba_map
  import cpba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [WADDR_W-1:0]   raddr,
  output logic [WORD_BITS-1:0] rdata,
  input  map_wr_t              wr
);

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] row_valid;
  logic [WORD_BITS-1:0] rword;
  logic                 rvalid;

  // Write the row and mark it valid
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr.we) begin
      row_valid[wr.addr] <= 1'b1;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rword  <= mem[raddr];
    rvalid <= row_valid[raddr];
  end

  assign rdata = rvalid ? rword : '0;

endmodule

/* hw/rtl/cpba_fit.sv */
// ----------------------------------------------------------------------------
// cpba_fit
// Run fit unit: over a two-word window of busy bits, find the lowest start
// in the lower word that begins a run of count free pages.
// ----------------------------------------------------------------------------
module cpba_fit
  import cpba_pkg::*;
(
  input  logic [WORD_BITS-1:0] lo_busy,
  input  logic [WORD_BITS-1:0] hi_busy,
  input  logic [CNT_W-1:0]     count,
  output fit_t                 fit
);

  logic [2*WORD_BITS-1:0] win_free;
  logic [WORD_BITS-1:0]   cmask;
  logic [WORD_BITS-1:0]   start_ok;
  logic [WORD_BITS-1:0]   first_ok;
  logic [OFF_W-1:0]       off;

  assign win_free = ~{hi_busy, lo_busy};
  assign cmask    = (WORD_BITS'(1) << count) - WORD_BITS'(1);

  // Check every start in parallel
  always_comb begin
    for (int s = 0; s < WORD_BITS; s++) begin
      start_ok[s] = &(win_free[s +: WORD_BITS] | ~cmask);
    end
  end

  // Isolate the lowest hit and encode it
  assign first_ok = start_ok & (~start_ok + WORD_BITS'(1));

  always_comb begin
    off = '0;
    for (int s = 0; s < WORD_BITS; s++) begin
      if (first_ok[s]) begin
        off = off | OFF_W'(s);
      end
    end
  end

  assign fit.found = |start_ok;
  assign fit.off   = off;

endmodule

/* hw/rtl/contiguous_page_bitmap_allocator_core.sv */
// ----------------------------------------------------------------------------
// contiguous_page_bitmap_allocator_core
// First-fit contiguous page allocator over a 4096-page used/free bitmap.
// ----------------------------------------------------------------------------
// Sequence: allocate scans one map word per cycle through the single read port
//   of the map in 65 window steps; free reads the two words of the run. Both then
//   write the low word and, unless it is the last map word, the high word.
// Throughput: one item at a time; a new item is taken once the block is idle.
// Reset (synchronous, rst high): map reads as all free at once (row valid
//   bits), used count zero, num_pages 4096, reserved_pages 0.
module contiguous_page_bitmap_allocator_core
  import cpba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_wdata,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // page_count[5:0], phys_address[53:6], zero pad
  input  logic        s_axis_tuser,   // func[0]
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // status[2:0], first_page[14:3], used_count[27:15]
);

  state_t state, state_next;

  logic [REG_W-1:0]     num_pages;
  logic [REG_W-1:0]     reserved_pages;
  logic [REG_W-1:0]     used_total;
  logic [REG_W-1:0]     used_next;
  logic [REG_W-1:0]     limit;

  logic                 func;
  logic [CNT_W-1:0]     cnt;
  logic [STAT_W-1:0]    status;
  logic [PAGE_W-1:0]    first;
  logic [WADDR_W-1:0]   base;
  logic [OFF_W-1:0]     off;
  logic [WORD_BITS-1:0] raw_lo;
  logic [WORD_BITS-1:0] raw_hi;

  logic [WADDR_W+1:0]   sc;
  logic                 pv;
  logic [WADDR_W:0]     pidx;
  logic [WORD_BITS-1:0] prev_busy;
  logic [WORD_BITS-1:0] prev_raw;
  logic [WORD_BITS-1:0] cur_raw;
  logic [WORD_BITS-1:0] cur_busy;
  logic [WORD_BITS-1:0] bound_busy;

  logic [WADDR_W-1:0]   raddr;
  logic [WORD_BITS-1:0] rdata;
  map_wr_t              map_wr;
  fit_t                 fit;

  logic                 in_accept;
  logic                 in_func;
  logic [CNT_W-1:0]     in_cnt;
  logic [ADDR_W-1:0]    in_addr;
  logic [PIDX_W-1:0]    in_idx;
  logic                 in_misalign;
  logic                 in_range;
  logic                 out_load;
  logic                 pidx_last;
  logic [WADDR_W-1:0]   found_word;

  logic [2*WORD_BITS-1:0] run_mask;
  logic [REG_W:0]         used_sum;

  // Unpack the request
  assign in_accept   = s_axis_tvalid && s_axis_tready;
  assign in_func     = s_axis_tuser;
  assign in_cnt      = s_axis_tdata[CNT_W-1:0];
  assign in_addr     = s_axis_tdata[CNT_W +: ADDR_W];
  assign in_idx      = in_addr[ADDR_W-1:PAGE_SHIFT];
  assign in_misalign = |in_addr[PAGE_SHIFT-1:0];
  assign in_range    = ({1'b0, in_idx} + (PIDX_W+1)'(in_cnt)) > (PIDX_W+1)'(limit);

  assign limit = (num_pages > PAGE_LIM) ? PAGE_LIM : num_pages;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_pages      <= PAGE_LIM;
      reserved_pages <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_PAGES: num_pages      <= cfg_wdata;
        REG_RESERVED:  reserved_pages <= cfg_wdata;
        default:       num_pages      <= num_pages;
      endcase
    end
  end

  // Page map and run fit unit
  cpba_map u_map (
    .clk   (clk),
    .rst   (rst),
    .raddr (raddr),
    .rdata (rdata),
    .wr    (map_wr)
  );

  // Word past the end of the map reads as empty; bounds make it busy
  assign pidx_last = pidx[WADDR_W];
  assign cur_raw   = pidx_last ? '0 : rdata;

  always_comb begin
    logic [REG_W-1:0] page;
    for (int j = 0; j < WORD_BITS; j++) begin
      page          = {pidx, OFF_W'(j)};
      bound_busy[j] = (page < reserved_pages) || (page >= limit);
    end
  end

  assign cur_busy = cur_raw | bound_busy;

  cpba_fit u_fit (
    .lo_busy (prev_busy),
    .hi_busy (cur_busy),
    .count   (cnt),
    .fit     (fit)
  );

  assign found_word = WADDR_W'(pidx - (WADDR_W+1)'(1));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_cnt == '0) begin
            state_next = ST_DONE;
          end else if (in_func == FUNC_ALLOC) begin
            state_next = ST_SCAN;
          end else if (in_misalign || in_range) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_FREE_RD0;
          end
        end
      end
      ST_SCAN: begin
        if (pv && fit.found) begin
          state_next = ST_WR_LO;
        end else if (pv && pidx_last) begin
          state_next = ST_DONE;
        end
      end
      ST_FREE_RD0: state_next = ST_FREE_RD1;
      ST_FREE_RD1: state_next = ST_FREE_CAP;
      ST_FREE_CAP: state_next = ST_WR_LO;
      ST_WR_LO:    state_next = (base == WADDR_W'(MAP_WORDS - 1)) ? ST_DONE : ST_WR_HI;
      ST_WR_HI:    state_next = ST_DONE;
      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // Mask of the run over the two words it can touch
  assign run_mask = {{WORD_BITS{1'b0}}, (WORD_BITS'(1) << cnt) - WORD_BITS'(1)} << off;

  // Outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    raddr         = '0;
    out_load      = 1'b0;
    map_wr.we     = 1'b0;
    map_wr.addr   = base;
    map_wr.data   = raw_lo;
    unique case (state)
      ST_IDLE:     s_axis_tready = 1'b1;
      ST_SCAN:     raddr = sc[WADDR_W-1:0];
      ST_FREE_RD0: raddr = base;
      ST_FREE_RD1: raddr = base + WADDR_W'(1);
      ST_WR_LO: begin
        map_wr.we   = 1'b1;
        map_wr.data = (func == FUNC_FREE) ? (raw_lo & ~run_mask[WORD_BITS-1:0])
                                          : (raw_lo | run_mask[WORD_BITS-1:0]);
      end
      ST_WR_HI: begin
        map_wr.we   = 1'b1;
        map_wr.addr = base + WADDR_W'(1);
        map_wr.data = (func == FUNC_FREE) ? (raw_hi & ~run_mask[2*WORD_BITS-1:WORD_BITS])
                                          : (raw_hi | run_mask[2*WORD_BITS-1:WORD_BITS]);
      end
      ST_DONE:     out_load = !m_axis_tvalid || m_axis_tready;
      default:     s_axis_tready = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pv            <= 1'b0;
      m_axis_tvalid <= 1'b0;
      used_total    <= '0;
    end else begin
      state <= state_next;
      pv    <= (state == ST_SCAN) && (state_next == ST_SCAN) &&
               (sc <= (WADDR_W+2)'(MAP_WORDS));
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        used_total    <= used_next;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Used count after the current item
  assign used_sum = {1'b0, used_total} + (REG_W+1)'(cnt);

  always_comb begin
    used_next = used_total;
    if (status == STAT_OK) begin
      if (func == FUNC_ALLOC) begin
        used_next = (used_sum > (REG_W+1)'(USED_MAX)) ? USED_MAX : used_sum[REG_W-1:0];
      end else begin
        used_next = (used_total > REG_W'(cnt)) ? (used_total - REG_W'(cnt)) : '0;
      end
    end
  end

  // Item and scan datapath
  always_ff @(posedge clk) begin
    pidx <= sc[WADDR_W:0];
    if (state == ST_SCAN && sc <= (WADDR_W+2)'(MAP_WORDS)) begin
      sc <= sc + (WADDR_W+2)'(1);
    end
    if (in_accept) begin
      func      <= in_func;
      cnt       <= in_cnt;
      base      <= in_idx[OFF_W +: WADDR_W];
      off       <= in_idx[OFF_W-1:0];
      first     <= in_idx[PAGE_W-1:0];
      sc        <= '0;
      prev_busy <= '1;
      prev_raw  <= '0;
      if (in_cnt == '0) begin
        status <= STAT_BAD_COUNT;
      end else if (in_func == FUNC_FREE && in_misalign) begin
        status <= STAT_MISALIGN;
      end else if (in_func == FUNC_FREE && in_range) begin
        status <= STAT_RANGE;
      end else begin
        status <= STAT_OK;
      end
    end
    // Step the window one word up, hold the run that fits, or mark no room at the end
    if (state == ST_SCAN && pv) begin
      if (fit.found) begin
        base   <= found_word;
        off    <= fit.off;
        first  <= {found_word, fit.off};
        raw_lo <= prev_raw;
        raw_hi <= cur_raw;
      end else if (pidx_last) begin
        status <= STAT_NO_ROOM;
      end else begin
        prev_busy <= cur_busy;
        prev_raw  <= cur_raw;
      end
    end
    if (state == ST_FREE_RD1) begin
      raw_lo <= rdata;
    end
    if (state == ST_FREE_CAP) begin
      raw_hi <= rdata;
    end
    if (out_load) begin
      m_axis_tdata <= {4'b0, used_next, (status == STAT_OK) ? first : PAGE_W'(0), status};
    end
  end

  // Checks
  a_err_first_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[2:0] != STAT_OK) |-> (m_axis_tdata[14:3] == '0))
    else $error("error result carries a nonzero first page");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !s_axis_tready)
    else $error("block ready again right after taking an item");

  a_scan_stage: assert property (@(posedge clk) disable iff (rst)
    pv |-> (state == ST_SCAN))
    else $error("scan stage active outside the scan");

endmodule

/* dv/contiguous_page_bitmap_allocator_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_page_bitmap_allocator_core_tb
// Self-checking bench for the first-fit page allocator. A short directed table
// covers counts of zero, misaligned and out-of-range frees, no room, and
// oversized registers. Phases of random allocate and free items follow under
// several register settings, all but one with random gaps on both streams.
// Every result is checked against its table value or a bit-level bench page map.
// ----------------------------------------------------------------------------
module contiguous_page_bitmap_allocator_core_tb;
  import cpba_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PAGE_W-1:0] first_page;
    logic [REG_W-1:0]  used_count;
  } page_result_t;

  typedef struct {
    int first;
    int cnt;
  } page_run_t;

  typedef struct {
    bit           is_cfg;
    logic         cfg_idx;
    logic [12:0]  cfg_val;
    logic         fn;
    logic [5:0]   cnt;
    logic [47:0]  addr;
    bit           known;
    page_result_t want;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [12:0] cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;   // page_count[5:0], phys_address[53:6], zero pad
  logic        s_axis_tuser;   // func[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // status[2:0], first_page[14:3], used_count[27:15]

  // Bench copy of the allocator state and registers
  logic [MAX_PAGES-1:0] page_used = '0;
  logic [REG_W-1:0]     used_total = '0;
  logic [REG_W-1:0]     num_pages_q = PAGE_LIM;
  logic [REG_W-1:0]     reserved_q = '0;

  page_result_t pending_results[$];
  page_run_t    live_runs[$];
  plan_row_t    directed_plan[$];
  page_result_t got_result;
  page_result_t want_result;
  int           mismatch_count = 0;
  bit           gaps_on = 1'b1;

  // Register settings per random phase; -1 picks a random value
  int phase_np [12] = '{4096, 8191, 0, 1, 64, 4096, 8191, 130, -1, -1, 4096, -1};
  int phase_rp [12] = '{0, 0, 0, 0, 0, 4096, 8191, 3, -1, -1, 0, -1};
  int phase_len[12] = '{200, 150, 40, 60, 150, 60, 40, 150, 200, 200, 300, 280};

  contiguous_page_bitmap_allocator_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int page_limit_now();
    return (num_pages_q > PAGE_LIM) ? MAX_PAGES : int'(num_pages_q);
  endfunction

  // Apply one request to the bench page map and return the result it gives
  function automatic page_result_t apply_page_request(logic fn, logic [5:0] cnt,
                                                      logic [47:0] addr);
    page_result_t      r;
    page_run_t         rr;
    int                lim, run, idx, hit, sum;
    logic [PIDX_W-1:0] pidx;
    r = '0;
    lim = page_limit_now();
    pidx = addr[ADDR_W-1:PAGE_SHIFT];
    if (cnt == '0) begin
      r.status = STAT_BAD_COUNT;
    end else if (fn == FUNC_ALLOC) begin
      // First fit: track the length of the free run ending at each page
      run = 0;
      hit = -1;
      for (idx = 0; idx < lim && hit < 0; idx++) begin
        if (idx < int'(reserved_q) || page_used[idx]) run = 0;
        else run++;
        if (run == int'(cnt)) hit = idx - run + 1;
      end
      if (hit < 0) begin
        r.status = STAT_NO_ROOM;
      end else begin
        for (idx = hit; idx < hit + int'(cnt); idx++) page_used[idx] = 1'b1;
        sum = int'(used_total) + int'(cnt);
        used_total = (sum > int'(USED_MAX)) ? USED_MAX : REG_W'(sum);
        r.first_page = PAGE_W'(hit);
        rr.first = hit;
        rr.cnt = int'(cnt);
        live_runs.push_back(rr);
      end
    end else if (addr[PAGE_SHIFT-1:0] != '0) begin
      r.status = STAT_MISALIGN;
    end else if (int'(pidx) + int'(cnt) > lim) begin
      r.status = STAT_RANGE;
    end else begin
      for (idx = int'(pidx); idx < int'(pidx) + int'(cnt); idx++) page_used[idx] = 1'b0;
      used_total = (used_total > cnt) ? used_total - cnt : '0;
      r.first_page = pidx[PAGE_W-1:0];
    end
    r.used_count = used_total;
    return r;
  endfunction

  function automatic void plan_req(logic fn, logic [5:0] cnt, logic [47:0] addr, bit known,
                                   logic [2:0] st, int first, int used);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.cfg_idx = REG_NUM_PAGES;
    row.cfg_val = '0;
    row.fn = fn;
    row.cnt = cnt;
    row.addr = addr;
    row.known = known;
    row.want.status = st;
    row.want.first_page = PAGE_W'(first);
    row.want.used_count = REG_W'(used);
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_cfg(logic idx, logic [12:0] val);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = val;
    directed_plan.push_back(row);
  endfunction

  // Offer one item; predict its result once it is taken
  task automatic send_req(logic fn, logic [5:0] cnt, logic [47:0] addr, bit known,
                          page_result_t want);
    page_result_t pred;
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, addr, cnt};
    s_axis_tuser  <= fn;
    do @(posedge clk); while (!s_axis_tready);
    pred = apply_page_request(fn, cnt, addr);
    pending_results.push_back(known ? want : pred);
  endtask

  // Hold the request stream and wait for every pending result
  task automatic drain_results();
    int waited;
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [12:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_NUM_PAGES) num_pages_q = val;
    else reserved_q = val;
  endtask

  // Mostly well-formed traffic: allocations and frees of runs handed out
  // earlier, plus stray frees, misaligned addresses and zero counts
  task automatic pick_request(output logic fn, output logic [5:0] cnt,
                              output logic [47:0] addr);
    int pick, lim, j;
    lim = page_limit_now();
    pick = $urandom_range(99);
    addr = 48'({$urandom, $urandom});
    fn = FUNC_FREE;
    cnt = 6'($urandom_range(1, 63));
    if (pick < 45) begin
      fn = FUNC_ALLOC;
      if ($urandom_range(1)) cnt = 6'($urandom_range(1, 8));
    end else if (pick < 70 && live_runs.size() > 0) begin
      j = $urandom_range(live_runs.size() - 1);
      addr = 48'(live_runs[j].first) << PAGE_SHIFT;
      cnt = 6'(live_runs[j].cnt);
      live_runs.delete(j);
    end else if (pick < 82) begin
      addr = 48'($urandom_range(lim > 0 ? lim - 1 : 0)) << PAGE_SHIFT;
      if ($urandom_range(1)) cnt = 6'($urandom_range(1, 4));
    end else if (pick < 90) begin
      cnt = 6'($urandom_range(63));
    end else if (pick < 95) begin
      cnt = '0;
      fn = 1'($urandom_range(1));
    end else begin
      addr[PAGE_SHIFT-1:0] = '0;
    end
  endtask

  // Result stream ready, with random back-pressure
  always @(negedge clk) begin
    m_axis_tready <= gaps_on ? ($urandom_range(99) >= 22) : 1'b1;
  end

  // Compare each result with the oldest pending expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_result.status     = m_axis_tdata[2:0];
      got_result.first_page = m_axis_tdata[14:3];
      got_result.used_count = m_axis_tdata[27:15];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d first_page %0d used_count %0d",
                   got_result.status, got_result.first_page, got_result.used_count);
      end else begin
        want_result = pending_results.pop_front();
        if (got_result.status !== want_result.status ||
            got_result.first_page !== want_result.first_page ||
            got_result.used_count !== want_result.used_count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected status %0d first_page %0d used_count %0d, got %0d %0d %0d",
                     want_result.status, want_result.first_page, want_result.used_count,
                     got_result.status, got_result.first_page, got_result.used_count);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic        fn;
    logic [5:0]  cnt;
    logic [47:0] addr;
    int          ph, n, np, rp, r;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_NUM_PAGES;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_ALLOC;
    m_axis_tready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table; rows with known=0 are checked against the page map
    plan_req(FUNC_ALLOC, 0, '0, 1, STAT_BAD_COUNT, 0, 0);
    plan_req(FUNC_FREE, 0, '0, 1, STAT_BAD_COUNT, 0, 0);
    plan_req(FUNC_ALLOC, 1, '0, 1, STAT_OK, 0, 1);
    plan_req(FUNC_ALLOC, 63, '1, 1, STAT_OK, 1, 64);
    plan_req(FUNC_FREE, 1, 48'd1, 1, STAT_MISALIGN, 0, 64);
    plan_req(FUNC_FREE, 1, '1, 1, STAT_MISALIGN, 0, 64);
    plan_req(FUNC_FREE, 2, 48'd4095 << PAGE_SHIFT, 1, STAT_RANGE, 0, 64);
    plan_req(FUNC_FREE, 63, 48'hFFFF_FFE0_0000, 1, STAT_RANGE, 0, 64);
    plan_req(FUNC_FREE, 1, 48'd4095 << PAGE_SHIFT, 1, STAT_OK, 4095, 63);
    plan_req(FUNC_FREE, 63, '0, 1, STAT_OK, 0, 0);
    // used count floors at zero
    plan_req(FUNC_FREE, 63, '0, 1, STAT_OK, 0, 0);
    plan_cfg(REG_NUM_PAGES, 13'd8);
    plan_req(FUNC_ALLOC, 9, '0, 1, STAT_NO_ROOM, 0, 0);
    plan_req(FUNC_ALLOC, 8, '0, 1, STAT_OK, 0, 8);
    plan_req(FUNC_ALLOC, 1, '0, 1, STAT_NO_ROOM, 0, 8);
    // reserved above the limit: every page held, frees still clear
    plan_cfg(REG_RESERVED, 13'd8191);
    plan_req(FUNC_FREE, 8, '0, 1, STAT_OK, 0, 0);
    plan_req(FUNC_ALLOC, 1, '0, 1, STAT_NO_ROOM, 0, 0);
    // oversized page count acts as the full map
    plan_cfg(REG_NUM_PAGES, 13'd8191);
    plan_cfg(REG_RESERVED, 13'd70);
    plan_req(FUNC_ALLOC, 60, '0, 0, STAT_OK, 0, 0);
    plan_req(FUNC_ALLOC, 10, '0, 0, STAT_OK, 0, 0);
    plan_req(FUNC_FREE, 1, 48'd4095 << PAGE_SHIFT, 0, STAT_OK, 0, 0);
    plan_req(FUNC_FREE, 1, 48'd4096 << PAGE_SHIFT, 0, STAT_OK, 0, 0);
    plan_cfg(REG_RESERVED, 13'd0);
    plan_req(FUNC_ALLOC, 63, '0, 0, STAT_OK, 0, 0);
    plan_req(FUNC_ALLOC, 3, '0, 0, STAT_OK, 0, 0);
    plan_req(FUNC_FREE, 2, 48'd63 << PAGE_SHIFT, 0, STAT_OK, 0, 0);
    plan_req(FUNC_ALLOC, 4, '0, 0, STAT_OK, 0, 0);

    for (r = 0; r < directed_plan.size(); r++) begin
      if (directed_plan[r].is_cfg) begin
        drain_results();
        cfg_write(directed_plan[r].cfg_idx, directed_plan[r].cfg_val);
      end else begin
        send_req(directed_plan[r].fn, directed_plan[r].cnt, directed_plan[r].addr,
                 directed_plan[r].known, directed_plan[r].want);
      end
    end

    // Random phases, registers rewritten while idle before each
    for (ph = 0; ph < 12; ph++) begin
      drain_results();
      np = (phase_np[ph] < 0) ? $urandom_range(1, 4096) : phase_np[ph];
      rp = (phase_rp[ph] < 0) ? $urandom_range(0, 64) : phase_rp[ph];
      cfg_write(REG_NUM_PAGES, 13'(np));
      cfg_write(REG_RESERVED, 13'(rp));
      gaps_on = (ph != 10);
      for (n = 0; n < phase_len[ph]; n++) begin
        if (ph == 8 && n == 100) drain_results();
        pick_request(fn, cnt, addr);
        send_req(fn, cnt, addr, 1'b0, '0);
      end
    end

    drain_results();
    repeat (80) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
